// ----- rtl/core/frm_pkg.sv -----
// shared types and constants for the frame rms level meter
// no dependencies

package frm_pkg;

  localparam int MAX_FRAMES_DEF = 256;
  localparam int QDEPTH = 2;

  localparam logic [20:0] KDB = 21'd1972830;
  // 904 * 2^32 + 2^31 - 200*log10(32767) in q.32
  localparam logic [32:0] KOFS = 33'd6067344725;
  localparam logic [11:0] BIAS_TENTHS = 12'd904;

  localparam logic signed [11:0] LOUD_TH = -12'sd150;
  localparam logic signed [11:0] MODERATE_TH = -12'sd300;
  localparam logic signed [11:0] QUIET_TH = -12'sd500;

  localparam logic [1:0] CLS_SILENT = 2'd0;
  localparam logic [1:0] CLS_QUIET = 2'd1;
  localparam logic [1:0] CLS_MODERATE = 2'd2;
  localparam logic [1:0] CLS_LOUD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLAMP,
    ST_NORM,
    ST_LOG,
    ST_MUL,
    ST_FIN
  } frm_state_t;

endpackage

// ----- rtl/core/frame_rms_dbfs_meter.sv -----
// frame rms meter top: accumulator, frame queue and level unit
// depends on frm_pkg, frm_accum, frm_fifo, frm_level
// samples are taken one per cycle while the queue is not full; the closing sample is queued in the same cycle
// each frame then passes the level unit's divide, clamp, normalize, log, multiply and finish states,
// the bit-serial divider working over a dividend of D = 47 + log2(MAX_FRAMES) bits
// the queue holds two closed frames; full rises while both slots are taken
// synchronous reset clears the open frame, the queue and any waiting result

module frame_rms_dbfs_meter import frm_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample,
  input  logic               last_sample,
  output logic               empty,
  input  logic               pop,
  output logic signed [10:0] level_tenths_db,
  output logic [1:0]         loudness_class,
  output logic [8:0]         sample_count
);

  localparam int CW = ($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9;
  localparam int SW = 31 + $clog2(MAX_FRAMES);
  localparam int QW = SW + CW;

  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  frm_accum #(.MAX_FRAMES(MAX_FRAMES)) u_accum (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .last_sample (last_sample),
    .q_wr        (q_wr),
    .q_wdata     (q_wdata),
    .q_full      (q_full)
  );

  frm_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  frm_level #(.MAX_FRAMES(MAX_FRAMES)) u_level (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .q_rdata         (q_rdata),
    .empty           (empty),
    .pop             (pop),
    .level_tenths_db (level_tenths_db),
    .loudness_class  (loudness_class),
    .sample_count    (sample_count)
  );

endmodule

// ----- rtl/core/frm_fifo.sv -----
// two-entry queue of closed frames between accumulator and level unit
// depends on frm_pkg

module frm_fifo import frm_pkg::*; #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  logic [W-1:0] mem [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CNTW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == CNTW'(QDEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/frm_accum.sv -----
// front end: squares samples, keeps the running frame sum and count
// depends on frm_pkg

module frm_accum import frm_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   sample,
  input  logic                 last_sample,
  output logic                 q_wr,
  output logic [31 + $clog2(MAX_FRAMES) +
                (($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9) - 1:0] q_wdata,
  input  logic                 q_full
);

  localparam int CW = ($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9;
  localparam int SW = 31 + $clog2(MAX_FRAMES);

  logic [SW-1:0] square_sum;
  logic [CW-1:0] samples_seen;
  logic signed [31:0] prod;
  logic [SW-1:0] sum_next;
  logic [CW-1:0] cnt_next;
  logic accept;
  logic close;

  assign full = q_full;
  assign accept = push && !q_full;
  assign prod = 32'(sample) * 32'(sample);
  assign sum_next = square_sum + SW'(prod[30:0]);
  assign cnt_next = samples_seen + 1'b1;
  assign close = last_sample || (cnt_next == CW'(MAX_FRAMES));
  assign q_wr = accept && close;
  assign q_wdata = {sum_next, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      samples_seen <= '0;
    end else if (accept) begin
      if (close) begin
        square_sum <= '0;
        samples_seen <= '0;
      end else begin
        square_sum <= sum_next;
        samples_seen <= cnt_next;
      end
    end
  end

endmodule

// ----- rtl/core/frm_level.sv -----
// back end: mean square divide, log2, scale to tenths of a db, result register
// depends on frm_pkg

module frm_level import frm_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_rd,
  input  logic [31 + $clog2(MAX_FRAMES) +
                (($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9) - 1:0] q_rdata,
  output logic               empty,
  input  logic               pop,
  output logic signed [10:0] level_tenths_db,
  output logic [1:0]         loudness_class,
  output logic [8:0]         sample_count
);

  localparam int CW = ($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9;
  localparam int SW = 31 + $clog2(MAX_FRAMES);
  localparam int DW = SW + 16;
  localparam int DCW = $clog2(DW + 1);
  localparam int SHW = $clog2(DW);
  localparam int LW = SHW + 16;
  localparam int PW = LW + 21;
  localparam int UW = PW + 1;
  localparam logic [SHW-1:0] INT_TOP = SHW'(DW - 17);

  frm_state_t state;
  frm_state_t state_next;

  logic [DW-1:0] dvd;
  logic [CW-1:0] rem;
  logic [CW-1:0] n;
  logic [DCW-1:0] dcnt;
  logic [SHW-1:0] sh;
  logic [30:0] y;
  logic [15:0] frac;
  logic [3:0] iter;
  logic [PW-1:0] p;
  logic ovalid;

  logic [CW:0] trial;
  logic ge;
  logic [61:0] sq;
  logic [31:0] t;
  logic [LW-1:0] lval;
  logic [UW-1:0] u;
  logic signed [11:0] lvl;
  logic [1:0] cls;
  logic out_free;
  logic load_out;

  assign out_free = !ovalid || pop;
  assign empty = !ovalid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (!q_empty) state_next = ST_DIV;
      ST_DIV:   if (dcnt == DCW'(1)) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_NORM;
      ST_NORM:  if (dvd[DW-1]) state_next = ST_LOG;
      ST_LOG:   if (iter == 4'd15) state_next = ST_MUL;
      ST_MUL:   state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_rd = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: q_rd = !q_empty;
      ST_FIN:  load_out = out_free;
      default: begin
        q_rd = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign trial = {rem, dvd[DW-1]};
  assign ge = (trial >= {1'b0, n});
  assign sq = 62'(y) * 62'(y);
  assign t = sq[61:30];
  assign lval = {INT_TOP - sh, frac};
  assign u = {1'b0, p} + UW'(KOFS);
  assign lvl = 12'(u[UW-1:32]) - BIAS_TENTHS;

  always_comb begin
    if (lvl > LOUD_TH) begin
      cls = CLS_LOUD;
    end else if (lvl > MODERATE_TH) begin
      cls = CLS_MODERATE;
    end else if (lvl > QUIET_TH) begin
      cls = CLS_QUIET;
    end else begin
      cls = CLS_SILENT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          dvd <= {q_rdata[CW +: SW], 16'd0};
          n <= q_rdata[CW-1:0];
          rem <= '0;
          dcnt <= DCW'(DW);
        end
      end
      ST_DIV: begin
        rem <= ge ? CW'(trial - {1'b0, n}) : trial[CW-1:0];
        dvd <= {dvd[DW-2:0], ge};
        dcnt <= dcnt - 1'b1;
      end
      ST_CLAMP: begin
        if (dvd[DW-1:16] == '0) begin
          dvd <= DW'(1) << 16;
        end
        sh <= '0;
      end
      ST_NORM: begin
        if (!dvd[DW-1]) begin
          dvd <= {dvd[DW-2:0], 1'b0};
          sh <= sh + 1'b1;
        end else begin
          y <= dvd[DW-1 -: 31];
          frac <= '0;
          iter <= '0;
        end
      end
      ST_LOG: begin
        y <= t[31] ? t[31:1] : t[30:0];
        frac <= {frac[14:0], t[31]};
        iter <= iter + 1'b1;
      end
      ST_MUL: begin
        p <= PW'(lval) * PW'(KDB);
      end
      default: begin
        p <= p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      level_tenths_db <= lvl[10:0];
      loudness_class <= cls;
      sample_count <= n[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_out) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOG |-> y[30])
    else $error("log mantissa not normalized");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < n)
    else $error("divider remainder not below count");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    state == ST_NORM |-> dvd[DW-1:16] != '0)
    else $error("mean square below one after clamp");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !pop |=> ovalid && $stable(level_tenths_db) && $stable(sample_count))
    else $error("waiting result changed");

endmodule
